FILE: hdl/ouks_pkg.sv
// shared constants, codes and types of the ordered unique key set unit
package ouks_pkg;

   // number of entries the set can hold
   localparam int CAPACITY = 16;

   // internal entry count width, wide enough to hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // payload field widths
   localparam int KEY_W     = 32;
   localparam int HANDLE_W  = 16;
   localparam int REQ_W     = 2;
   localparam int STATUS_W  = 3;
   localparam int COUNT_O_W = 5;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_POP    = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic valid;  // cell holds a live entry
      logic load;   // write the broadcast key and handle
      logic shift;  // take the entry of the upper neighbor
   } cell_ctl_type;

endpackage

FILE: hdl/ouks_req_if.sv
// request channel: valid/ready handshake with request payload
interface ouks_req_if;
   import ouks_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [REQ_W-1:0]            req_type;
   logic signed [KEY_W-1:0]     key;
   logic [HANDLE_W-1:0]         entry_handle;

   modport source (output valid, output req_type, output key, output entry_handle,
                   input ready);
   modport sink   (input valid, input req_type, input key, input entry_handle,
                   output ready);
endinterface

FILE: hdl/ouks_rsp_if.sv
// response channel: valid/ready handshake with response payload
interface ouks_rsp_if;
   import ouks_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [STATUS_W-1:0]         status;
   logic signed [KEY_W-1:0]     out_key;
   logic [HANDLE_W-1:0]         out_handle;
   logic [COUNT_O_W-1:0]        entry_count;

   modport source (output valid, output status, output out_key, output out_handle,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input out_key, input out_handle,
                   input entry_count, output ready);
endinterface

FILE: hdl/ouks_cell.sv
// one storage cell of the key chain: holds an entry, compares, shifts down
module ouks_cell (
   input  logic                              clock,
   input  ouks_pkg::cell_ctl_type            ctl,
   input  logic signed [ouks_pkg::KEY_W-1:0] cmp_key,
   input  logic [ouks_pkg::HANDLE_W-1:0]     new_handle,
   input  logic signed [ouks_pkg::KEY_W-1:0] nbr_key,
   input  logic [ouks_pkg::HANDLE_W-1:0]     nbr_handle,
   input  logic                              seen_in,
   output logic signed [ouks_pkg::KEY_W-1:0] key,
   output logic [ouks_pkg::HANDLE_W-1:0]     handle,
   output logic                              hit,
   output logic                              seen_out
);
   import ouks_pkg::*;

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [HANDLE_W-1:0]     handle_ff, handle_in;

   // key match on a live entry, and the running "match at or below" flag
   assign hit      = ctl.valid && (key_ff == cmp_key);
   assign seen_out = seen_in | hit;

   // append writes the broadcast entry, remove pulls the neighbor down
   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (ctl.load) begin
         key_in    = cmp_key;
         handle_in = new_handle;
      end else if (ctl.shift) begin
         key_in    = nbr_key;
         handle_in = nbr_handle;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign key    = key_ff;
   assign handle = handle_ff;

endmodule

FILE: hdl/ordered_unique_key_set_unit.sv
// top level of the ordered unique key set unit: cell chain, sequencer, response register
//
// The unit keeps up to CAPACITY (16) key/handle entries in insertion order in a chain of
// cells. Every request (add, remove by key, pop last, lookup by key) is handled in one pass:
// all cells compare the request key at once, a match flag ripples up the chain, and on a
// remove the matching cell and every cell above it take the upper neighbor's entry in the
// same clock edge. One request is accepted per cycle while the response register is free
// or being drained, so throughput is one transaction per clock; the response is registered
// and valid in the cycle after acceptance. Each request yields exactly one response with a
// status, the entry touched (zero for adds and misses) and the entry count after the
// request. No clearing pass follows reset; only the count and response valid are cleared.
module ordered_unique_key_set_unit (
   input  logic       clock,
   input  logic       reset,
   ouks_req_if.sink   req_bus,
   ouks_rsp_if.source rsp_bus
);
   import ouks_pkg::*;

   // entry count and response register
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic signed [KEY_W-1:0] out_key_ff, out_key_in;
   logic [HANDLE_W-1:0]     out_handle_ff, out_handle_in;

   // cell chain wiring
   cell_ctl_type            ctl      [CAPACITY];
   logic signed [KEY_W-1:0] cell_key [CAPACITY];
   logic [HANDLE_W-1:0]     cell_hdl [CAPACITY];
   logic [CAPACITY-1:0]     hit_vec;
   logic [CAPACITY-1:0]     seen_vec;
   logic [CAPACITY-1:0]     pop_vec;
   logic [CAPACITY-1:0]     sel_vec;

   logic   accept;
   op_type op;
   logic   any_hit;
   logic   is_full;
   logic   is_empty;
   logic   append_go;
   logic   remove_go;

   // handshake: take a new transaction whenever the response slot frees up
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign op            = op_type'(req_bus.req_type);

   assign any_hit   = seen_vec[CAPACITY-1];
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign append_go = accept && (op == OP_ADD) && !any_hit && !is_full;
   assign remove_go = accept && (op == OP_REMOVE) && any_hit;

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] nbr_key;
      logic [HANDLE_W-1:0]     nbr_hdl;
      logic                    seen_in;

      if (i == CAPACITY - 1) begin : g_top
         assign nbr_key = cell_key[i];
         assign nbr_hdl = cell_hdl[i];
      end else begin : g_mid
         assign nbr_key = cell_key[i+1];
         assign nbr_hdl = cell_hdl[i+1];
      end

      if (i == 0) begin : g_first
         assign seen_in = 1'b0;
      end else begin : g_rest
         assign seen_in = seen_vec[i-1];
      end

      // per-cell control: live flag, append slot, shift at and above the removed entry
      assign ctl[i].valid = (CNT_W'(i) < count_ff);
      assign ctl[i].load  = append_go && (count_ff == CNT_W'(i));
      assign ctl[i].shift = remove_go && seen_vec[i];
      assign pop_vec[i]   = (count_ff == CNT_W'(i + 1));

      ouks_cell u_cell (
         .clock      (clock),
         .ctl        (ctl[i]),
         .cmp_key    (req_bus.key),
         .new_handle (req_bus.entry_handle),
         .nbr_key    (nbr_key),
         .nbr_handle (nbr_hdl),
         .seen_in    (seen_in),
         .key        (cell_key[i]),
         .handle     (cell_hdl[i]),
         .hit        (hit_vec[i]),
         .seen_out   (seen_vec[i])
      );
   end

   // result selection, status and count update
   always_comb begin
      sel_vec       = '0;
      status_in     = status_ff;
      out_key_in    = out_key_ff;
      out_handle_in = out_handle_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;

      unique case (op)
         OP_REMOVE, OP_LOOKUP: sel_vec = hit_vec;
         OP_POP:               sel_vec = pop_vec;
         OP_ADD:               sel_vec = '0;
         default:              sel_vec = '0;
      endcase

      if (accept) begin
         rsp_valid_in  = 1'b1;
         out_key_in    = '0;
         out_handle_in = '0;
         for (int j = 0; j < CAPACITY; j++) begin
            out_key_in    = out_key_in    | (cell_key[j] & {KEY_W{sel_vec[j]}});
            out_handle_in = out_handle_in | (cell_hdl[j] & {HANDLE_W{sel_vec[j]}});
         end

         unique case (op)
            OP_ADD: begin
               priority if (any_hit) begin
                  status_in = ST_DUPLICATE;
               end else if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (any_hit) begin
                  status_in = ST_DONE;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
            OP_POP: begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  status_in = ST_DONE;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            OP_LOOKUP: begin
               status_in = any_hit ? ST_DONE : ST_NOT_FOUND;
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      out_key_ff    <= out_key_in;
      out_handle_ff <= out_handle_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.out_key     = out_key_ff;
   assign rsp_bus.out_handle  = out_handle_ff;
   assign rsp_bus.entry_count = COUNT_O_W'(count_ff);

`ifndef ASSERT_OFF
   // held keys stay unique, so at most one cell matches
   assert property (@(posedge clock) disable iff (reset) $onehot0(hit_vec))
      else $error("more than one cell matches the request key");

   // the count never exceeds the capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // an accepted transaction always produces a response next cycle
   assert property (@(posedge clock) disable iff (reset) accept |=> rsp_valid_ff)
      else $error("accepted transaction without response");

   // a successful append grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      append_go |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not grow the count");

   // append and shift never hit the same cell
   assert property (@(posedge clock) disable iff (reset) !(append_go && remove_go))
      else $error("append and remove in the same cycle");
`endif

endmodule
